@@ rtl/gme_pkg.sv @@
// ----------------------------------------------------------------------------
// gme_pkg: shared types and constants of the Gram matrix entry engine
// Holds the transfer payloads, the internal job format passed from the front
// end to the back end, and the back-end sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package gme_pkg;

    localparam int IDX_W   = 6;   // row_index, col_index, entry_row, entry_col
    localparam int ELEM_W  = 16;  // Q0.16 matrix element
    localparam int PROD_W  = 32;  // Q0.32 product of two elements
    localparam int ENTRY_W = 38;  // Q6.32 dot product
    localparam int SIZE_W  = 7;   // matrix_size register

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic              command;
        logic [IDX_W-1:0]  row_index;
        logic [IDX_W-1:0]  col_index;
        logic [ELEM_W-1:0] element_value;
    } t_in_item;

    typedef struct packed {
        logic [ENTRY_W-1:0] product_entry;
        logic [IDX_W-1:0]   entry_row;
        logic [IDX_W-1:0]   entry_col;
    } t_out_item;

    // Work classes decided by the front end.
    typedef enum logic [1:0] {
        OP_WRITE,       // store one element
        OP_QUERY,       // accumulate the dot product of two stored rows
        OP_ZERO         // query naming a row beyond capacity: result is zero
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [ELEM_W-1:0] value;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_back_state;

endpackage

`default_nettype wire

@@ rtl/gme_front.sv @@
// ----------------------------------------------------------------------------
// gme_front: input front end of the Gram matrix entry engine
// Accepts input transfers, classifies each as an element write, a row-pair
// query or an out-of-range query, drops writes beyond capacity, and holds the
// resulting jobs in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gme_front
    import gme_pkg::*;
#(
    parameter int MAX_SIZE = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_item,
    output logic          o_job_valid,
    output t_job          o_job,
    input  wire logic     i_job_pop
);

    localparam int ROW_W = $clog2(MAX_SIZE);
    localparam int EXT_W = ((ROW_W > IDX_W) ? ROW_W : IDX_W) + 1;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    logic row_ok, col_ok, accept, push, pop;
    t_job job_in;

    always_comb begin
        row_ok = EXT_W'(i_in_item.row_index) < EXT_W'(MAX_SIZE);
        col_ok = EXT_W'(i_in_item.col_index) < EXT_W'(MAX_SIZE);

        job_in.row   = i_in_item.row_index;
        job_in.col   = i_in_item.col_index;
        job_in.value = i_in_item.element_value;
        if (i_in_item.command == CMD_QUERY) begin
            job_in.op = (row_ok && col_ok) ? OP_QUERY : OP_ZERO;
        end else begin
            job_in.op = OP_WRITE;
        end

        o_in_stall = (r_count == CNT_W'(QUEUE_DEPTH));
        accept     = i_in_valid && !o_in_stall;
        // A write outside the matrix is taken and forgotten.
        push = accept && !((i_in_item.command == CMD_WRITE) && !(row_ok && col_ok));

        o_job_valid = (r_count != '0);
        o_job       = r_slot[r_rd_ptr];
        pop         = i_job_pop && o_job_valid;

        n_wr_ptr = push ? PTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = pop  ? PTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = CNT_W'(r_count + 1'b1);
        end else if (pop && !push) begin
            n_count = CNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= job_in;
        end
    end

endmodule

`default_nettype wire

@@ rtl/gme_back.sv @@
// ----------------------------------------------------------------------------
// gme_back: execution back end of the Gram matrix entry engine
// Owns the matrix memory, performs element writes, and runs queries through a
// shared multiply-accumulate pipeline, one column per cycle, into an output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module gme_back
    import gme_pkg::*;
#(
    parameter int MAX_SIZE = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [$clog2(MAX_SIZE+1)-1:0]  i_size,
    input  wire logic                           i_job_valid,
    input  wire t_job                           i_job,
    output logic                                o_job_pop,
    output logic                                o_out_valid,
    output t_out_item                           o_out_item,
    input  wire logic                           i_out_stall
);

    localparam int ROW_W  = $clog2(MAX_SIZE);
    localparam int CNT_W  = $clog2(MAX_SIZE + 1);
    localparam int EXT_W  = (ROW_W > IDX_W) ? ROW_W : IDX_W;
    localparam int ADDR_W = 2 * ROW_W;
    localparam int DEPTH  = 1 << ADDR_W;

    logic [ELEM_W-1:0] mem [DEPTH];

    t_back_state r_state, n_state;
    logic [CNT_W-1:0] r_k, n_k;
    logic [ROW_W-1:0] r_row_i, r_row_j;
    logic [IDX_W-1:0] r_echo_i, r_echo_j;
    logic [ELEM_W-1:0] r_rd_a, r_rd_b;
    logic [PROD_W-1:0] r_prod;
    logic [ENTRY_W-1:0] r_acc;
    logic r_v1, r_v2;
    logic r_out_valid;
    t_out_item r_out;

    logic [EXT_W-1:0] job_row_ext, job_col_ext;
    logic wr_en, issue, start, acc_clr, load_out, slot_free;
    logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;

    always_comb begin
        job_row_ext = EXT_W'(i_job.row);
        job_col_ext = EXT_W'(i_job.col);
        wr_addr   = {job_row_ext[ROW_W-1:0], job_col_ext[ROW_W-1:0]};
        rd_addr_a = {r_row_i, r_k[ROW_W-1:0]};
        rd_addr_b = {r_row_j, r_k[ROW_W-1:0]};
        slot_free = !r_out_valid || !i_out_stall;

        n_state   = r_state;
        n_k       = r_k;
        wr_en     = 1'b0;
        issue     = 1'b0;
        start     = 1'b0;
        acc_clr   = 1'b0;
        load_out  = 1'b0;
        o_job_pop = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    unique case (i_job.op)
                        OP_WRITE: begin
                            wr_en = 1'b1;
                        end
                        OP_QUERY: begin
                            start   = 1'b1;
                            acc_clr = 1'b1;
                            n_k     = '0;
                            n_state = (i_size == '0) ? ST_DONE : ST_RUN;
                        end
                        OP_ZERO: begin
                            start   = 1'b1;
                            acc_clr = 1'b1;
                            n_state = ST_DONE;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                issue = 1'b1;
                n_k   = CNT_W'(r_k + 1'b1);
                if (CNT_W'(r_k + 1'b1) == i_size) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last product reaches the accumulator at the same edge
                // that moves the sequencer on.
                if (!r_v1) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_job.value;
        end
        r_rd_a <= mem[rd_addr_a];
        r_rd_b <= mem[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_prod <= r_rd_a * r_rd_b;
        if (start) begin
            r_row_i  <= job_row_ext[ROW_W-1:0];
            r_row_j  <= job_col_ext[ROW_W-1:0];
            r_echo_i <= i_job.row;
            r_echo_j <= i_job.col;
        end
        if (acc_clr) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ENTRY_W'(r_prod);
        end
        if (load_out) begin
            r_out.product_entry <= r_acc;
            r_out.entry_row     <= r_echo_i;
            r_out.entry_col     <= r_echo_j;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

@@ rtl/gram_matrix_engine.sv @@
// ----------------------------------------------------------------------------
// gram_matrix_engine: entries of A times A-transpose on demand
// Stores a square matrix of unsigned Q0.16 elements written one at a time and
// answers row-pair queries with the exact dot product of the two rows over
// the first matrix_size columns, in unsigned Q6.32.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Payload
//   --------  ---------  -----------------  ---------------------------------
//   in        input      i_in_valid/o_in_stall    t_in_item: write or query
//   out       output     o_out_valid/i_out_stall  t_out_item: one per query
//   cfg       input      i_cfg_valid/o_cfg_ready  matrix_size, 7 bits
//
// An element write is done in the back end as the job is popped. A query
// starts, streams the first n column pairs, where n is matrix_size capped at
// MAX_SIZE, through the two read ports of the matrix memory into the shared
// multiply-accumulate unit, lets the read and multiply stages drain, and
// then loads the output register. Reset is synchronous and active low; it
// clears the job queue, the sequencer and the output valid and sets
// matrix_size to 64, while the matrix memory keeps no defined contents until
// written. A stalled output holds its result while the back end starts on the
// next job, and the two-entry job queue lets the input side run ahead until
// it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module gram_matrix_engine
    import gme_pkg::*;
#(
    parameter int MAX_SIZE = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_item          i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_item              o_out_item,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [SIZE_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_SIZE + 1);
    localparam int CMP_W = ((CNT_W > SIZE_W) ? CNT_W : SIZE_W) + 1;

    // Configuration register. Writes must arrive only while the engine is idle;
    // the block does not enforce this, and the port can always take a transfer.
    logic [SIZE_W-1:0] r_matrix_size;
    logic [CMP_W-1:0]  size_ext;
    logic [CNT_W-1:0]  eff_size;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_matrix_size <= i_cfg_data;
        end
    end

    // A size above the memory capacity sums every stored column.
    always_comb begin
        size_ext = CMP_W'(r_matrix_size);
        if (size_ext > CMP_W'(MAX_SIZE)) begin
            eff_size = CNT_W'(MAX_SIZE);
        end else begin
            eff_size = size_ext[CNT_W-1:0];
        end
    end

    logic job_valid, job_pop;
    t_job job;

    gme_front #(
        .MAX_SIZE (MAX_SIZE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    gme_back #(
        .MAX_SIZE (MAX_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_size      (eff_size),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

@@ sim/gram_entry_checker.sv @@
// ----------------------------------------------------------------------------
// gram_entry_checker: predicts and checks Gram matrix entries
// Watches the input, output and configuration channels of the engine, keeps
// its own copy of the matrix and of matrix_size, works out the dot product of
// each accepted query and compares it with the next transfer on the output.
// ----------------------------------------------------------------------------
module gram_entry_checker
    import gme_pkg::*;
#(
    parameter int MAX_SIZE = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_in_item          i_in_item,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_out_item         i_out_item,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [SIZE_W-1:0] i_cfg_data,
    output int                o_outstanding,
    output int                o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [ELEM_W-1:0] matrix_copy [MAX_SIZE][MAX_SIZE];
    logic [SIZE_W-1:0] size_copy = SIZE_RESET;
    t_out_item         awaited_entries [$];
    int                failures = 0;

    assign o_fail_count = failures;

    initial o_outstanding = 0;

    // Sum of A[ri][k] * A[rj][k] over the columns in use, kept to the 38 bits
    // of the result field.
    function automatic logic [ENTRY_W-1:0] dot_of_rows(input logic [IDX_W-1:0] ri,
                                                        input logic [IDX_W-1:0] rj);
        logic [ENTRY_W-1:0] acc;
        int                 cols;
        int                 k;
        acc  = '0;
        cols = (int'(size_copy) > MAX_SIZE) ? MAX_SIZE : int'(size_copy);
        if (int'(ri) < MAX_SIZE && int'(rj) < MAX_SIZE) begin
            for (k = 0; k < cols; k++) begin
                acc = acc + ENTRY_W'(matrix_copy[ri][k]) * ENTRY_W'(matrix_copy[rj][k]);
            end
        end
        return acc;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            size_copy = SIZE_RESET;
            awaited_entries.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_entries.size() == 0) begin
                    $display("%0t: unexpected result transfer, got entry (%0d,%0d) = %0d",
                             $time, i_out_item.entry_row, i_out_item.entry_col,
                             i_out_item.product_entry);
                    failures++;
                end else begin
                    want = awaited_entries.pop_front();
                    if (i_out_item.product_entry !== want.product_entry) begin
                        $display("%0t: product_entry mismatch, expected %0d, actual %0d",
                                 $time, want.product_entry, i_out_item.product_entry);
                        failures++;
                    end
                    if (i_out_item.entry_row !== want.entry_row) begin
                        $display("%0t: entry_row mismatch, expected %0d, actual %0d",
                                 $time, want.entry_row, i_out_item.entry_row);
                        failures++;
                    end
                    if (i_out_item.entry_col !== want.entry_col) begin
                        $display("%0t: entry_col mismatch, expected %0d, actual %0d",
                                 $time, want.entry_col, i_out_item.entry_col);
                        failures++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                size_copy = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_item.command == CMD_WRITE) begin
                    if (int'(i_in_item.row_index) < MAX_SIZE &&
                        int'(i_in_item.col_index) < MAX_SIZE) begin
                        matrix_copy[i_in_item.row_index][i_in_item.col_index] =
                            i_in_item.element_value;
                    end
                end else begin
                    want.product_entry = dot_of_rows(i_in_item.row_index,
                                                     i_in_item.col_index);
                    want.entry_row     = i_in_item.row_index;
                    want.entry_col     = i_in_item.col_index;
                    awaited_entries.push_back(want);
                end
            end
        end
        o_outstanding <= awaited_entries.size();
    end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench of the Gram matrix entry engine
// Writes matrix elements and asks for row-pair dot products under a series of
// matrix_size settings, with random bursts on the input, a random stall
// pattern on the output and one long output hold-off. A separate checker
// predicts every entry and counts mismatches; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gme_pkg::*;

    localparam int MAX_SIZE      = 64;
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 12;
    // The settle time is sized from the longest query. After the last result
    // only element writes can still be in flight, so this is a comfortable
    // margin before touching the size register.
    localparam int SETTLE_CYCLES = 2 * (MAX_SIZE + 4);
    // Long output hold-off, long enough to fill the job queue and the output
    // register and to push back on the input.
    localparam int HOLD_CYCLES   = 600;
    // The slowest honest run (every item a full-size query waiting out heavy
    // stalls) stays well inside this limit.
    localparam int CYCLE_LIMIT   = 600000;

    typedef enum int {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS
    } t_fill_style;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    t_in_item          in_item = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out_item         out_item;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data = '0;
    int                outstanding;
    int                fail_count;

    // Which elements have been written so far. A query only ever names rows
    // whose first matrix_size columns are all written, because reading a
    // never-written element is outside what the engine promises.
    logic [MAX_SIZE-1:0] written_cols [MAX_SIZE];

    int eff_size;       // matrix_size as the engine uses it, capped at MAX_SIZE
    int burst_left = 0; // transfers left in the current input burst
    int phase_items;    // items offered in the current phase
    bit hold_armed = 0; // asks the output side for one long hold-off
    int cycle_count = 0;

    gram_matrix_engine #(
        .MAX_SIZE(MAX_SIZE)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    gram_entry_checker #(
        .MAX_SIZE(MAX_SIZE)
    ) checker_inst (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_item    (out_item),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .o_outstanding (outstanding),
        .o_fail_count  (fail_count)
    );

    initial begin
        forever begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Watchdog: a hang or a lost result ends the run here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: FAIL");
        $finish;
    end

    // Output side. The stall pattern changes mode every so often: no stall at
    // all, light, even or heavy random stalls. When asked, it holds off for a
    // long stretch while the input side keeps offering items.
    initial begin
        int stall_mode;
        int span_left;
        int hold_left;
        stall_mode = 0;
        span_left  = 0;
        hold_left  = 0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (hold_armed) begin
                hold_armed = 0;
                hold_left  = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end else begin
                if (span_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    span_left  = $urandom_range(20, 200);
                end
                span_left--;
                case (stall_mode)
                    0: begin
                        out_stall <= 1'b0;
                    end
                    1: begin
                        out_stall <= ($urandom_range(0, 3) == 0);
                    end
                    2: begin
                        out_stall <= ($urandom_range(0, 1) == 0);
                    end
                    default: begin
                        out_stall <= ($urandom_range(0, 9) != 0);
                    end
                endcase
            end
        end
    end

    // Offers one item and returns at the edge where it was transferred. The
    // input side works in bursts; between bursts valid drops for a random gap,
    // and some bursts are long stretches with no gap at all.
    task automatic send_item(input logic cmd, input int row, input int col,
                             input logic [ELEM_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_item  <= '{command: cmd, row_index: IDX_W'(row), col_index: IDX_W'(col),
                      element_value: value};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        phase_items++;
        if (cmd == CMD_WRITE) begin
            written_cols[row][col] = 1'b1;
        end
    endtask

    // Queries carry a random element_value, which the engine must ignore.
    task automatic ask_entry(input int row_i, input int row_j);
        send_item(CMD_QUERY, row_i, row_j, ELEM_W'($urandom));
    endtask

    // Drops valid, waits for every expected entry and then lets the engine
    // finish any element write still queued behind the last query.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes matrix_size while the engine is idle.
    task automatic set_size(input logic [SIZE_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        eff_size = (int'(value) > MAX_SIZE) ? MAX_SIZE : int'(value);
    endtask

    function automatic bit row_ready(input int row);
        logic [MAX_SIZE-1:0] need;
        need = (eff_size >= MAX_SIZE) ? '1 : ((MAX_SIZE'(1) << eff_size) - 1);
        return (written_cols[row] & need) == need;
    endfunction

    // Writes the first matrix_size columns of one row, in either order.
    task automatic fill_row(input int row, input t_fill_style style);
        int                k;
        int                col;
        bit                downward;
        logic [ELEM_W-1:0] value;
        downward = $urandom_range(0, 1);
        for (k = 0; k < eff_size; k++) begin
            col = downward ? eff_size - 1 - k : k;
            case (style)
                FILL_ONES:  value = '1;
                FILL_ZEROS: value = '0;
                default:    value = ELEM_W'($urandom);
            endcase
            send_item(CMD_WRITE, row, col, value);
        end
    endtask

    // Random traffic under the current size. Most of it is the sequence that
    // matters (complete a row, then ask for its products with other complete
    // rows); the rest is stray writes anywhere, which also leave rows
    // half-written and overwrite rows already in use.
    task automatic run_phase(input int budget);
        int ready_rows [$];
        int row;
        int pick;
        int k;
        int strays;
        t_fill_style style;
        phase_items = 0;
        while (phase_items < budget) begin
            ready_rows.delete();
            for (k = 0; k < MAX_SIZE; k++) begin
                if (row_ready(k)) ready_rows.push_back(k);
            end
            pick = $urandom_range(0, 99);
            if (ready_rows.size() < 2 || pick < 10) begin
                row = $urandom_range(0, MAX_SIZE - 1);
                k   = $urandom_range(0, 3);
                style = (k == 1) ? FILL_ONES : (k == 2) ? FILL_ZEROS : FILL_RANDOM;
                fill_row(row, style);
                if (ready_rows.size() == 0) begin
                    ask_entry(row, row);
                end else if ($urandom_range(0, 1) == 0) begin
                    ask_entry(row, ready_rows[$urandom_range(0, ready_rows.size() - 1)]);
                end else begin
                    ask_entry(ready_rows[$urandom_range(0, ready_rows.size() - 1)], row);
                end
            end else if (pick < 30) begin
                strays = $urandom_range(1, 4);
                repeat (strays) begin
                    send_item(CMD_WRITE, $urandom_range(0, MAX_SIZE - 1),
                              $urandom_range(0, MAX_SIZE - 1), ELEM_W'($urandom));
                end
            end else begin
                ask_entry(ready_rows[$urandom_range(0, ready_rows.size() - 1)],
                          ready_rows[$urandom_range(0, ready_rows.size() - 1)]);
            end
        end
    endtask

    initial begin
        int k;
        for (k = 0; k < MAX_SIZE; k++) written_cols[k] = '0;
        eff_size = MAX_SIZE;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-column matrix: extremes of indices and values, including
        // the largest single product and products with a zero element.
        set_size(7'd1);
        send_item(CMD_WRITE, 0, 0, 16'hFFFF);
        send_item(CMD_WRITE, 63, 0, 16'hFFFF);
        send_item(CMD_WRITE, 1, 0, 16'h0000);
        send_item(CMD_WRITE, 62, 0, 16'h8001);
        send_item(CMD_WRITE, 63, 63, 16'hFFFF);
        send_item(CMD_WRITE, 0, 63, 16'h0001);
        send_item(CMD_WRITE, 21, 42, 16'hAAAA);
        send_item(CMD_WRITE, 42, 21, 16'h5555);
        ask_entry(0, 0);
        ask_entry(0, 63);
        ask_entry(63, 0);
        ask_entry(1, 0);
        ask_entry(62, 63);
        ask_entry(62, 62);

        // A size of zero sums nothing, so any row pair may be named, even
        // rows that were never written.
        set_size(7'd0);
        ask_entry(21, 42);
        ask_entry(63, 63);
        ask_entry(5, 0);

        // A size above capacity acts as the full 64 columns. Two rows of all
        // ones give the largest entry the engine can produce.
        set_size(7'd127);
        fill_row(0, FILL_ONES);
        fill_row(63, FILL_ONES);
        ask_entry(0, 63);
        ask_entry(63, 63);
        run_phase(90);

        // Small matrix with the long output hold-off, so the job queue and the
        // output register fill and the engine stalls its input.
        set_size(7'd4);
        hold_armed = 1;
        run_phase(100);

        set_size(7'd64);
        run_phase(120);

        set_size(7'd1);
        run_phase(40);

        set_size(7'd0);
        run_phase(20);

        set_size(SIZE_W'($urandom_range(2, 63)));
        run_phase(130);

        set_size(SIZE_W'($urandom_range(65, 126)));
        run_phase(100);

        settle();
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/gme_pkg.sv
rtl/gme_front.sv
rtl/gme_back.sv
rtl/gram_matrix_engine.sv
sim/gram_entry_checker.sv
sim/tb.sv
